FILE: design/deq_pkg.sv
// shared constants, codes and control structs for the double-ended queue
// no dependencies; imported by every design file

package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);
  localparam int WORD_W     = 32;
  localparam int ACT_W      = 2;
  localparam int STAT_W     = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic                 exec;
    logic                 push_front;
    logic                 push_back;
    logic                 pop_front;
    logic                 pop_back;
    logic [STAT_W-1:0]    err;
  } deq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } deq_stat_t;

endpackage

FILE: design/deq_ctrl.sv
// controller: accepts one word at a time, decodes the action against the
// full/empty flags and sequences the result cycle; uses deq_pkg

module deq_ctrl
  import deq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACT_W-1:0] action,
  input  deq_stat_t        dp_stat,
  output deq_cmd_t         cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DONE = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = start && (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // decode: illegal pushes/pops turn into an error code with no datapath move
  always_comb begin
    cmd            = '0;
    cmd.exec       = accept;
    cmd.err        = ST_OK;
    if (accept) begin
      if (action inside {ACT_PUSH_FRONT, ACT_PUSH_BACK}) begin
        if (dp_stat.full) begin
          cmd.err = ST_FULL;
        end else begin
          cmd.push_front = (action == ACT_PUSH_FRONT);
          cmd.push_back  = (action == ACT_PUSH_BACK);
        end
      end else begin
        if (dp_stat.empty) begin
          cmd.err = ST_EMPTY;
        end else begin
          cmd.pop_front = (action == ACT_POP_FRONT);
          cmd.pop_back  = (action == ACT_POP_BACK);
        end
      end
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

FILE: design/deq_dp.sv
// datapath: slot memory, front/back pointers, entry count and result regs
// uses deq_pkg; driven by deq_ctrl commands

module deq_dp
  import deq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  deq_cmd_t           cmd,
  input  logic [WORD_W-1:0]  push_word,
  output deq_stat_t          dp_stat,
  output logic [WORD_W-1:0]  pop_word,
  output logic [STAT_W-1:0]  status,
  output logic [COUNT_W-1:0] entry_count,
  output logic               is_empty
);

  localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [PTR_W-1:0]      front, back;
  logic [PTR_W-1:0]      front_prev, front_succ, back_prev, back_succ;
  logic [PTR_W-1:0]      wr_addr, rd_addr;
  logic [COUNT_W-1:0]    count;
  logic [STAT_W-1:0]     res_status;
  logic                  res_pop;
  logic                  wr_en, rd_en;

  assign front_prev = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign front_succ = (front == LAST_SLOT) ? '0 : front + 1'b1;
  assign back_prev  = (back == '0) ? LAST_SLOT : back - 1'b1;
  assign back_succ  = (back == LAST_SLOT) ? '0 : back + 1'b1;

  assign wr_en   = cmd.push_front || cmd.push_back;
  assign rd_en   = cmd.pop_front || cmd.pop_back;
  assign wr_addr = cmd.push_front ? front_prev : back;
  assign rd_addr = cmd.pop_front ? front : back_prev;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= push_word[DATA_WIDTH-1:0];
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else begin
      if (cmd.push_front) front <= front_prev;
      if (cmd.pop_front)  front <= front_succ;
      if (cmd.push_back)  back  <= back_succ;
      if (cmd.pop_back)   back  <= back_prev;
      if (wr_en)          count <= count + 1'b1;
      else if (rd_en)     count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= cmd.err;
      res_pop    <= rd_en;
    end
  end

  assign dp_stat.full  = (count == FULL_CNT);
  assign dp_stat.empty = (count == '0);

  assign pop_word    = res_pop ? WORD_W'(rd_data) : '0;
  assign status      = res_status;
  assign entry_count = count;
  assign is_empty    = (count == '0);

endmodule

FILE: design/double_ended_queue.sv
// Bounded double-ended queue of 16 words, push and pop at either end.
// In the cycle where start is taken (start high, busy low) the pointers and
// count move and the slot is written or read; the registered slot read
// fills the done state, in which done pulses for one cycle with the result
// and busy is high. A new word can be started in the cycle after done. A pop
// on an empty queue returns zero with the empty status; a push on a full
// queue is dropped with the full status. Slots need no clearing after reset.
// Results must be taken when done is high.
// depends on deq_pkg, deq_ctrl and deq_dp

module double_ended_queue
  import deq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [ACT_W-1:0]   action,
  input  logic [WORD_W-1:0]  push_word,
  output logic               done,
  output logic [WORD_W-1:0]  pop_word,
  output logic [STAT_W-1:0]  status,
  output logic [COUNT_W-1:0] entry_count,
  output logic               is_empty
);

  deq_cmd_t  cmd;
  deq_stat_t dp_stat;

  deq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .action  (action),
    .dp_stat (dp_stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  deq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .push_word   (push_word),
    .dp_stat     (dp_stat),
    .pop_word    (pop_word),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

endmodule

FILE: design/deq_checker.sv
// port-level checks for double_ended_queue, bound to the top level
// uses deq_pkg

module deq_checker
  import deq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [WORD_W-1:0]  pop_word,
  input logic [STAT_W-1:0]  status,
  input logic [COUNT_W-1:0] entry_count,
  input logic               is_empty
);

  // every accepted word gets its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("no result after accepted word");

  // one result per word
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held two cycles");

  // failed pop leaves an empty queue and a zero word
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> pop_word == '0 && is_empty && entry_count == '0)
    else $error("empty pop result inconsistent");

  // count never exceeds depth, and moves by at most one per word
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    done && $past(done, 2) |-> entry_count <= COUNT_W'(DEPTH) &&
      (entry_count == $past(entry_count, 2) ||
       entry_count == $past(entry_count, 2) + 1'b1 ||
       entry_count == $past(entry_count, 2) - 1'b1))
    else $error("entry count jumped");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .pop_word    (pop_word),
  .status      (status),
  .entry_count (entry_count),
  .is_empty    (is_empty)
);

FILE: sim/double_ended_queue_tb.sv
// self-checking testbench for the double-ended queue: directed table, then random words
// depends on deq_pkg and double_ended_queue; predicts results in its own deque model or takes them from the table

module double_ended_queue_tb;
  import deq_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]  pop_word;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } deq_result_t;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] word;
    bit                typed;
    deq_result_t       result;
  } deq_row_t;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DIRECTED_ROWS = 24;
  localparam int PHASE_WORDS   = 367;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [ACT_W-1:0]   action;
  logic [WORD_W-1:0]  push_word;
  logic               done;
  logic [WORD_W-1:0]  pop_word;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;
  logic               is_empty;

  // deque model state
  logic [DATA_WIDTH-1:0] model_slots [DEPTH];
  int                    model_front;
  int                    model_back;
  int                    model_fill;

  deq_result_t pending_results [$];
  deq_row_t    dir_rows [DIRECTED_ROWS];
  bit          row_typed;
  deq_result_t row_result;
  int          idle_pct;
  int          err_count;
  int          cycle_count;

  double_ended_queue uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .push_word   (push_word),
    .done        (done),
    .pop_word    (pop_word),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic deq_result_t deque_next_result(input logic [ACT_W-1:0] act,
                                                    input logic [WORD_W-1:0] word);
    deq_result_t r;
    r.pop_word = '0;
    r.status   = ST_OK;
    if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
      if (model_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else if (act == ACT_PUSH_FRONT) begin
        model_front = (model_front == 0) ? DEPTH - 1 : model_front - 1;
        model_slots[model_front] = word[DATA_WIDTH-1:0];
        model_fill++;
      end else begin
        model_slots[model_back] = word[DATA_WIDTH-1:0];
        model_back = (model_back == DEPTH - 1) ? 0 : model_back + 1;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        r.status = ST_EMPTY;
      end else if (act == ACT_POP_FRONT) begin
        r.pop_word = WORD_W'(model_slots[model_front]);
        model_front = (model_front == DEPTH - 1) ? 0 : model_front + 1;
        model_fill--;
      end else begin
        model_back = (model_back == 0) ? DEPTH - 1 : model_back - 1;
        r.pop_word = WORD_W'(model_slots[model_back]);
        model_fill--;
      end
    end
    r.entry_count = COUNT_W'(model_fill);
    r.is_empty    = (model_fill == 0);
    return r;
  endfunction

  // check the result first, then log the word taken at this edge
  always @(posedge clk) begin
    deq_result_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with no word outstanding");
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (pop_word !== want.pop_word) begin
            $error("pop_word expected %h actual %h", want.pop_word, pop_word);
            err_count++;
          end
          if (status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status);
            err_count++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count expected %0d actual %0d", want.entry_count, entry_count);
            err_count++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty expected %0d actual %0d", want.is_empty, is_empty);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        want = deque_next_result(action, push_word);
        if (row_typed) want = row_result;
        pending_results.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] word,
                           input bit typed, input deq_result_t res);
    while ($urandom_range(99) < idle_pct) begin
      start     = 1'b0;
      action    = ACT_W'($urandom);
      push_word = $urandom;
      row_typed = 1'b0;
      @(negedge clk);
    end
    start      = 1'b1;
    action     = act;
    push_word  = word;
    row_typed  = typed;
    row_result = res;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int                phase;
    int                burst_left;
    int                push_pct;
    bit                is_pop;
    logic [ACT_W-1:0]  act;
    logic [WORD_W-1:0] word;

    rst         = 1'b1;
    start       = 1'b0;
    action      = '0;
    push_word   = '0;
    row_typed   = 1'b0;
    row_result  = '0;
    idle_pct    = 0;
    err_count   = 0;
    cycle_count = 0;
    model_front = 0;
    model_back  = 0;
    model_fill  = 0;
    burst_left  = 0;
    push_pct    = 50;

    dir_rows[0] = '{ACT_POP_FRONT, 32'h0, 1'b1, '{32'h0, ST_EMPTY, COUNT_W'(0), 1'b1}};
    dir_rows[1] = '{ACT_POP_BACK, 32'hFFFF_FFFF, 1'b1,
                    '{32'h0, ST_EMPTY, COUNT_W'(0), 1'b1}};
    dir_rows[2] = '{ACT_PUSH_BACK, 32'hFFFF_FFFF, 1'b1,
                    '{32'h0, ST_OK, COUNT_W'(1), 1'b0}};
    // front pointer wraps below zero
    dir_rows[3] = '{ACT_PUSH_FRONT, 32'h0, 1'b1, '{32'h0, ST_OK, COUNT_W'(2), 1'b0}};
    dir_rows[4] = '{ACT_POP_BACK, 32'h1234_5678, 1'b1,
                    '{32'hFFFF_FFFF, ST_OK, COUNT_W'(1), 1'b0}};
    dir_rows[5] = '{ACT_POP_FRONT, 32'h0, 1'b1, '{32'h0, ST_OK, COUNT_W'(0), 1'b1}};
    for (int i = 6; i < DIRECTED_ROWS - 2; i++) begin
      dir_rows[i] = '{(i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, $urandom, 1'b0, '0};
    end
    dir_rows[DIRECTED_ROWS-2] = '{ACT_PUSH_FRONT, 32'hDEAD_BEEF, 1'b1,
                                  '{32'h0, ST_FULL, COUNT_W'(DEPTH), 1'b0}};
    dir_rows[DIRECTED_ROWS-1] = '{ACT_PUSH_BACK, 32'hFFFF_FFFF, 1'b1,
                                  '{32'h0, ST_FULL, COUNT_W'(DEPTH), 1'b0}};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(dir_rows[i].action, dir_rows[i].word, dir_rows[i].typed, dir_rows[i].result);
    end

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 22 : (phase == 1) ? 60 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // bursts that lean toward filling, draining or churning the queue
        if (burst_left == 0) begin
          burst_left = $urandom_range(40, 16);
          case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
          endcase
        end
        burst_left--;
        is_pop = ($urandom_range(99) >= push_pct);
        if (is_pop) act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
        else act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
        case ($urandom_range(7))
          0:       word = '0;
          1:       word = '1;
          2:       word = WORD_W'(1) << $urandom_range(WORD_W - 1);
          default: word = $urandom;
        endcase
        send_word(act, word, 1'b0, '0);
      end
    end

    start     = 1'b0;
    row_typed = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
